### src/psvf_pkg.sv
// Shared types, constants and helpers for the polyphonic SVF voice engine.
// Used by every module of the block; no dependencies of its own.
package psvf_pkg;

    localparam int VOICES      = 16;
    localparam int VOICE_W     = 4;
    localparam int SAMPLE_RATE = 48000;
    localparam int OUT_BITS    = 24;
    localparam int ENV_W       = 24;
    localparam int LVL_W       = 17;
    localparam int DIV_N       = 40;
    localparam int DIVR_W      = 16;
    localparam int DIVC_W      = 6;
    localparam int MUL_W       = 34;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ACC_W       = 40;

    localparam logic [ENV_W-1:0]  ENV_MAX  = '1;
    localparam logic [LVL_W-1:0]  FRAC_ONE = 17'h10000;

    // Request kinds carried on the stream user field
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_AMP_TIMES    = 3'd0,
        REG_AMP_SUSTAIN  = 3'd1,
        REG_FILT_TIMES   = 3'd2,
        REG_FILT_SUSTAIN = 3'd3,
        REG_CUTOFF       = 3'd4,
        REG_RESONANCE    = 3'd5,
        REG_WAVEFORM     = 3'd6,
        REG_SPARE        = 3'd7
    } t_reg;

    // Per-voice sequencer steps
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_V_START,
        ST_ENV_A,
        ST_ENV_W,
        ST_ENV_END,
        ST_SRC,
        ST_SRC_W,
        ST_F_SQ,
        ST_F_CU,
        ST_F_CO,
        ST_LOW_M,
        ST_LOW_W,
        ST_HIGH,
        ST_BAND_M,
        ST_BAND_W,
        ST_ACC_D,
        ST_ACC_W,
        ST_ACC_C,
        ST_OUT
    } t_state;

    // Divider request
    typedef struct packed {
        logic              start;
        logic [DIV_N-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } t_div_req;

    // Phase step of the top octave's twelve notes, shifted down for lower octaves
    localparam logic [47:0] STEP_BASE [16] = '{
        48'((64'd548668578  << 16) / SAMPLE_RATE),
        48'((64'd581294109  << 16) / SAMPLE_RATE),
        48'((64'd615859655  << 16) / SAMPLE_RATE),
        48'((64'd652480576  << 16) / SAMPLE_RATE),
        48'((64'd691279090  << 16) / SAMPLE_RATE),
        48'((64'd732384684  << 16) / SAMPLE_RATE),
        48'((64'd775934544  << 16) / SAMPLE_RATE),
        48'((64'd822074013  << 16) / SAMPLE_RATE),
        48'((64'd870957077  << 16) / SAMPLE_RATE),
        48'((64'd922746880  << 16) / SAMPLE_RATE),
        48'((64'd977616265  << 16) / SAMPLE_RATE),
        48'((64'd1035748353 << 16) / SAMPLE_RATE),
        48'd0, 48'd0, 48'd0, 48'd0
    };

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh000000007FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -64'sh0000000080000000) begin
            r = -32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Product shifted down by 16 with floor rounding, sign extended to 64 bits
    function automatic logic signed [63:0] shr16(input logic signed [PROD_W-1:0] p);
        return {{(64-(PROD_W-16)){p[PROD_W-1]}}, p[PROD_W-1:16]};
    endfunction

endpackage

### src/polyphonic_svf_synth_voice_engine_top.sv
// Top level of the sixteen-voice synth engine: sequencer, voice state, registers.
// Depends on psvf_pkg, psvf_div and psvf_mul.
//
//  Channel   Dir  Handshake              Payload
//  s stream  in   i_s_tvalid/o_s_tready  tuser: op; tdata: channel, pitch, velocity
//  m stream  out  o_m_tvalid/i_m_tready  tdata: sample_out
//  cfg       in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A tick runs the voices in turn, with up to two divider passes per voice (one per envelope).
// Reset clears all voice state and loads the register defaults.
// A finished sample waits in the output register; note events are still taken
// then, and the next tick stalls only at its end until the sample is taken.
module polyphonic_svf_synth_voice_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // channel[3:0], pitch[10:4], velocity[17:11], zeros
    input  logic [1:0]  i_s_tuser,   // op[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // sample_out[23:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int VW = psvf_pkg::VOICE_W;
    localparam int LW = psvf_pkg::LVL_W;
    localparam int MW = psvf_pkg::MUL_W;
    localparam int PW = psvf_pkg::PROD_W;
    localparam int AW = psvf_pkg::ACC_W;

    psvf_pkg::t_state r_state, n_state;

    // Configuration registers
    logic [31:0] r_amp_times, r_filt_times;
    logic [15:0] r_amp_sus, r_filt_sus, r_cutoff, r_res;
    logic [8:0]  r_wave;

    // Voice state
    logic [31:0]              r_phase [psvf_pkg::VOICES];
    logic [psvf_pkg::ENV_W-1:0] r_env [psvf_pkg::VOICES];
    logic                     r_active [psvf_pkg::VOICES];
    logic [6:0]               r_pitch [psvf_pkg::VOICES];
    logic [6:0]               r_level [psvf_pkg::VOICES];
    logic signed [31:0]       r_low_st [psvf_pkg::VOICES];
    logic signed [31:0]       r_band_st [psvf_pkg::VOICES];

    // Working registers
    logic [VW-1:0]                r_v;
    logic [psvf_pkg::ENV_W-1:0]   r_e;
    logic                         r_sel_filt;
    logic                         r_dmax;
    logic [LW-1:0]                r_envl;
    logic signed [23:0]           r_src;
    logic [LW-1:0]                r_coef;
    logic signed [31:0]           r_low;
    logic signed [31:0]           r_high;
    logic                         r_neg;
    logic [AW-1:0]                r_pabs;
    logic [AW-1:0]                r_q0;
    logic signed [psvf_pkg::ACC_W-1:0] r_acc;
    logic                         r_ovalid;
    logic [psvf_pkg::OUT_BITS-1:0] r_odata;

    // Unpacked request fields
    logic [1:0] w_op;
    logic [3:0] w_ch;
    logic [6:0] w_pitch, w_vel;
    logic       w_s_acc;

    assign w_op    = i_s_tuser;
    assign w_ch    = i_s_tdata[3:0];
    assign w_pitch = i_s_tdata[10:4];
    assign w_vel   = i_s_tdata[17:11];
    assign w_s_acc = i_s_tvalid && o_s_tready;

    // Shared units
    psvf_pkg::t_div_req           w_div_req;
    logic [psvf_pkg::DIV_N-1:0]   w_quot;
    logic                         w_div_done;
    logic signed [MW-1:0]         w_ma, w_mb;
    logic signed [PW-1:0]         w_prod;

    psvf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    psvf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    // Current voice's envelope selection and step values
    logic [31:0]                w_times;
    logic [15:0]                w_sus;
    logic [15:0]                w_att, w_dec;
    logic [psvf_pkg::ENV_W-1:0] w_t;
    logic                       w_in_att, w_at_sus;
    logic [LW-1:0]              w_qlvl;

    assign w_times  = r_sel_filt ? r_filt_times : r_amp_times;
    assign w_sus    = r_sel_filt ? r_filt_sus : r_amp_sus;
    assign w_att    = w_times[15:0];
    assign w_dec    = w_times[31:16];
    assign w_in_att = (r_e < {8'd0, w_att});
    assign w_t      = r_e - {8'd0, w_att};
    assign w_at_sus = (w_dec == 16'd0) || (w_t >= {8'd0, w_dec});
    assign w_qlvl   = (r_dmax && (w_quot[LW-1:0] < {1'b0, w_sus})) ? {1'b0, w_sus}
                                                                 : w_quot[LW-1:0];

    // Phase step from pitch: octave by reciprocal multiply, then table and shift
    logic [14:0] w_oct_prod;
    logic [3:0]  w_oct;
    logic [6:0]  w_semi;
    logic [31:0] w_step;
    logic [6:0]  w_cur_pitch;

    assign w_cur_pitch = r_pitch[r_v];
    assign w_oct_prod  = {8'd0, w_cur_pitch} * 15'd171;
    assign w_oct       = w_oct_prod[14:11];
    assign w_semi      = w_cur_pitch - (7'(w_oct) * 7'd12);
    assign w_step      = 32'(psvf_pkg::STEP_BASE[w_semi[3:0]] >> (4'd10 - w_oct));

    // Pulse comparison and filter arithmetic
    logic [8:0]          w_duty_sum;
    logic                w_up;
    logic [LW-1:0]       w_damp;
    logic signed [63:0]  w_low_sum, w_high_sum, w_band_sum;
    logic signed [PW-1:0] w_p_abs;

    assign w_duty_sum = {1'b0, r_phase[r_v][31:24]} + {1'b0, r_wave[7:0]};
    assign w_up       = (r_wave[7:0] != 8'd0) && w_duty_sum[8];
    assign w_damp     = psvf_pkg::FRAC_ONE - {1'b0, r_res};
    assign w_low_sum  = 64'(r_low_st[r_v]) + psvf_pkg::shr16(w_prod);
    assign w_high_sum = 64'(r_src) - 64'(r_low) - psvf_pkg::shr16(w_prod);
    assign w_band_sum = 64'(r_band_st[r_v]) + psvf_pkg::shr16(w_prod);
    assign w_p_abs    = w_prod[PW-1] ? (-w_prod + PW'(126)) : w_prod;

    // Divide by 127: series of shifts by 7 gives a quotient at most five short,
    // the remainder (below 762) then fixes it by constant compares
    logic [AW-1:0] w_q0, w_rem_full, w_q127;
    logic [9:0]    w_rem;
    logic [2:0]    w_fix;

    assign w_q0 = {7'd0, r_pabs[AW-1:7]} + {14'd0, r_pabs[AW-1:14]}
                + {21'd0, r_pabs[AW-1:21]} + {28'd0, r_pabs[AW-1:28]}
                + {35'd0, r_pabs[AW-1:35]};
    assign w_rem_full = r_pabs - {r_q0[AW-8:0], 7'd0} + r_q0;
    assign w_rem      = w_rem_full[9:0];
    assign w_fix      = {2'd0, (w_rem >= 10'd127)} + {2'd0, (w_rem >= 10'd254)}
                      + {2'd0, (w_rem >= 10'd381)} + {2'd0, (w_rem >= 10'd508)}
                      + {2'd0, (w_rem >= 10'd635)};
    assign w_q127     = r_q0 + {37'd0, w_fix};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            psvf_pkg::ST_IDLE: begin
                if (w_s_acc && (w_op == psvf_pkg::OP_TICK)) n_state = psvf_pkg::ST_V_START;
            end
            psvf_pkg::ST_V_START: n_state = psvf_pkg::ST_ENV_A;
            psvf_pkg::ST_ENV_A: begin
                if (!w_in_att && w_at_sus) n_state = psvf_pkg::ST_ENV_END;
                else n_state = psvf_pkg::ST_ENV_W;
            end
            psvf_pkg::ST_ENV_W: begin
                if (w_div_done) n_state = psvf_pkg::ST_ENV_END;
            end
            psvf_pkg::ST_ENV_END: n_state = r_sel_filt ? psvf_pkg::ST_F_SQ : psvf_pkg::ST_SRC;
            psvf_pkg::ST_SRC:     n_state = psvf_pkg::ST_SRC_W;
            psvf_pkg::ST_SRC_W:   n_state = psvf_pkg::ST_ENV_A;
            psvf_pkg::ST_F_SQ:    n_state = psvf_pkg::ST_F_CU;
            psvf_pkg::ST_F_CU:    n_state = psvf_pkg::ST_F_CO;
            psvf_pkg::ST_F_CO:    n_state = psvf_pkg::ST_LOW_M;
            psvf_pkg::ST_LOW_M:   n_state = psvf_pkg::ST_LOW_W;
            psvf_pkg::ST_LOW_W:   n_state = psvf_pkg::ST_HIGH;
            psvf_pkg::ST_HIGH:    n_state = psvf_pkg::ST_BAND_M;
            psvf_pkg::ST_BAND_M:  n_state = psvf_pkg::ST_BAND_W;
            psvf_pkg::ST_BAND_W:  n_state = psvf_pkg::ST_ACC_D;
            psvf_pkg::ST_ACC_D:   n_state = psvf_pkg::ST_ACC_W;
            psvf_pkg::ST_ACC_W:   n_state = psvf_pkg::ST_ACC_C;
            psvf_pkg::ST_ACC_C: begin
                n_state = (r_v == VW'(psvf_pkg::VOICES - 1)) ? psvf_pkg::ST_OUT
                                                             : psvf_pkg::ST_V_START;
            end
            psvf_pkg::ST_OUT: begin
                if (!r_ovalid || i_m_tready) n_state = psvf_pkg::ST_IDLE;
            end
            default: n_state = psvf_pkg::ST_IDLE;
        endcase
    end

    // Shared unit operands per step
    always_comb begin
        w_div_req = '0;
        w_ma      = '0;
        w_mb      = '0;
        case (r_state)
            psvf_pkg::ST_ENV_A: begin
                if (w_in_att) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = {8'd0, r_e[15:0], 16'd0};
                    w_div_req.divisor  = w_att;
                end else if (!w_at_sus) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = {8'd0, w_dec - w_t[15:0], 16'd0};
                    w_div_req.divisor  = w_dec;
                end
            end
            psvf_pkg::ST_SRC: begin
                w_ma = MW'($signed({~r_phase[r_v][31], r_phase[r_v][30:0]}));
                w_mb = MW'($signed({1'b0, r_envl}));
            end
            psvf_pkg::ST_F_SQ: begin
                w_ma = MW'($signed({1'b0, r_envl}));
                w_mb = MW'($signed({1'b0, r_envl}));
            end
            psvf_pkg::ST_F_CU: begin
                w_ma = MW'($signed({1'b0, w_prod[33:16]}));
                w_mb = MW'($signed({1'b0, r_envl}));
            end
            psvf_pkg::ST_F_CO: begin
                w_ma = MW'($signed({1'b0, w_prod[33:16]}));
                w_mb = MW'($signed({1'b0, r_cutoff}));
            end
            psvf_pkg::ST_LOW_M: begin
                w_ma = MW'($signed({1'b0, w_prod[32:16]}));
                w_mb = MW'(r_band_st[r_v]);
            end
            psvf_pkg::ST_LOW_W: begin
                w_ma = MW'($signed({1'b0, w_damp}));
                w_mb = MW'(r_band_st[r_v]);
            end
            psvf_pkg::ST_BAND_M: begin
                w_ma = MW'($signed({1'b0, r_coef}));
                w_mb = MW'(r_high);
            end
            psvf_pkg::ST_BAND_W: begin
                w_ma = MW'(r_low);
                w_mb = MW'($signed({1'b0, r_level[r_v]}));
            end
            default: begin
                w_div_req = '0;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psvf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_times  <= 32'd268435456;
            r_amp_sus    <= 16'd26214;
            r_filt_times <= 32'd268435456;
            r_filt_sus   <= 16'd26214;
            r_cutoff     <= 16'd6554;
            r_res        <= 16'd19661;
            r_wave       <= 9'd128;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                psvf_pkg::REG_AMP_TIMES:    r_amp_times  <= i_cfg_data;
                psvf_pkg::REG_AMP_SUSTAIN:  r_amp_sus    <= i_cfg_data[15:0];
                psvf_pkg::REG_FILT_TIMES:   r_filt_times <= i_cfg_data;
                psvf_pkg::REG_FILT_SUSTAIN: r_filt_sus   <= i_cfg_data[15:0];
                psvf_pkg::REG_CUTOFF:       r_cutoff     <= i_cfg_data[15:0];
                psvf_pkg::REG_RESONANCE:    r_res        <= i_cfg_data[15:0];
                psvf_pkg::REG_WAVEFORM:     r_wave       <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Voice state: note events, per-voice phase/envelope advance, filter write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < psvf_pkg::VOICES; i++) begin
                r_phase[i]   <= '0;
                r_env[i]     <= '0;
                r_active[i]  <= 1'b0;
                r_pitch[i]   <= '0;
                r_level[i]   <= '0;
                r_low_st[i]  <= '0;
                r_band_st[i] <= '0;
            end
        end else begin
            if ((r_state == psvf_pkg::ST_IDLE) && w_s_acc) begin
                if (w_op == psvf_pkg::OP_NOTE_ON) begin
                    r_pitch[w_ch]  <= w_pitch;
                    r_level[w_ch]  <= w_vel;
                    r_active[w_ch] <= 1'b1;
                    r_env[w_ch]    <= '0;
                end else if (w_op == psvf_pkg::OP_NOTE_OFF) begin
                    r_active[w_ch] <= 1'b0;
                end
            end
            if ((r_state == psvf_pkg::ST_V_START) && r_active[r_v]) begin
                r_phase[r_v] <= r_phase[r_v] + w_step;
                if (r_env[r_v] != psvf_pkg::ENV_MAX) r_env[r_v] <= r_env[r_v] + 1'b1;
            end
            if (r_state == psvf_pkg::ST_BAND_W) begin
                r_band_st[r_v] <= psvf_pkg::sat32(w_band_sum);
                r_low_st[r_v]  <= r_low;
            end
        end
    end

    // Sequencer working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_acc <= '0;
        end else begin
            case (r_state)
                psvf_pkg::ST_IDLE: begin
                    r_v   <= '0;
                    r_acc <= '0;
                end
                psvf_pkg::ST_V_START: begin
                    r_src      <= '0;
                    r_sel_filt <= !r_active[r_v];
                    if (r_active[r_v] && (r_env[r_v] != psvf_pkg::ENV_MAX)) begin
                        r_e <= r_env[r_v] + 1'b1;
                    end else begin
                        r_e <= r_env[r_v];
                    end
                end
                psvf_pkg::ST_ENV_A: begin
                    r_dmax <= !w_in_att;
                    if (!w_in_att && w_at_sus) r_envl <= {1'b0, w_sus};
                end
                psvf_pkg::ST_ENV_W: begin
                    if (w_div_done) r_envl <= w_qlvl;
                end
                psvf_pkg::ST_SRC_W: begin
                    r_sel_filt <= 1'b1;
                    if (r_wave[8]) begin
                        r_src <= w_up ? $signed({4'd0, r_envl, 3'd0})
                                      : -$signed({4'd0, r_envl, 3'd0});
                    end else begin
                        r_src <= w_prod[49:26];
                    end
                end
                psvf_pkg::ST_LOW_M: r_coef <= w_prod[32:16];
                psvf_pkg::ST_LOW_W: r_low  <= psvf_pkg::sat32(w_low_sum);
                psvf_pkg::ST_HIGH:  r_high <= psvf_pkg::sat32(w_high_sum);
                psvf_pkg::ST_ACC_D: begin
                    r_neg  <= w_prod[PW-1];
                    r_pabs <= w_p_abs[AW-1:0];
                end
                psvf_pkg::ST_ACC_W: r_q0 <= w_q0;
                psvf_pkg::ST_ACC_C: begin
                    r_acc <= r_neg ? (r_acc - $signed(w_q127)) : (r_acc + $signed(w_q127));
                    r_v   <= r_v + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Output register: saturate the mix and hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_tready) r_ovalid <= 1'b0;
            if ((r_state == psvf_pkg::ST_OUT) && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
                if (r_acc > 40'sh00007FFFFF) begin
                    r_odata <= 24'h7FFFFF;
                end else if (r_acc < -40'sh0000800000) begin
                    r_odata <= 24'h800000;
                end else begin
                    r_odata <= r_acc[23:0];
                end
            end
        end
    end

    assign o_s_tready  = (r_state == psvf_pkg::ST_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;
    assign o_cfg_ready = 1'b1;

endmodule

### src/psvf_div.sv
// Shared restoring divider: 40-bit dividend, 16-bit divisor, one bit a cycle.
// Depends on psvf_pkg for widths and the request struct.
module psvf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  psvf_pkg::t_div_req          i_req,
    output logic [psvf_pkg::DIV_N-1:0]  o_quot,
    output logic                        o_done
);

    logic [psvf_pkg::DIVR_W-1:0] r_rem, n_rem;
    logic [psvf_pkg::DIV_N-1:0]  r_quo, n_quo;
    logic [psvf_pkg::DIVR_W-1:0] r_dvs;
    logic [psvf_pkg::DIVC_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [psvf_pkg::DIVR_W:0]   w_trial;
    logic                        w_fit;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_quo[psvf_pkg::DIV_N-1]};
        w_fit   = (w_trial >= {1'b0, r_dvs});
        n_rem   = w_fit ? psvf_pkg::DIVR_W'(w_trial - {1'b0, r_dvs})
                        : w_trial[psvf_pkg::DIVR_W-1:0];
        n_quo   = {r_quo[psvf_pkg::DIV_N-2:0], w_fit};
    end

    // Hold control state, advance one bit per cycle while busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == psvf_pkg::DIVC_W'(psvf_pkg::DIV_N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and quotient registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quot = r_quo;
    assign o_done = r_done;

endmodule

### src/psvf_mul.sv
// Shared signed multiplier with a registered product.
// Depends on psvf_pkg for operand widths.
module psvf_mul (
    input  logic                                i_clk,
    input  logic signed [psvf_pkg::MUL_W-1:0]   i_a,
    input  logic signed [psvf_pkg::MUL_W-1:0]   i_b,
    output logic signed [psvf_pkg::PROD_W-1:0]  o_p
);

    logic signed [psvf_pkg::PROD_W-1:0] r_p;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

### src/psvf_chk.sv
// Port-level checker for the synth voice engine, bound to the top level.
// Depends on psvf_pkg for the request kind codes.
module psvf_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    // A tick request busies the engine on the next cycle
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == psvf_pkg::OP_TICK)) |=> !o_s_tready)
        else $error("tick request did not busy the engine");

    // A note event never produces a sample
    a_note_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser != psvf_pkg::OP_TICK) && !o_m_tvalid)
        |=> !o_m_tvalid)
        else $error("sample appeared after a note event");

    // Reset drops any pending sample
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("sample valid after reset");

    // A stalled sample holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled sample changed");

endmodule

bind polyphonic_svf_synth_voice_engine_top psvf_chk u_psvf_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

### tb/psvf_synth_checker.sv
// Checker for the polyphonic SVF voice engine: watches the request, sample and
// register channels, computes the expected mix per tick and compares samples.
// Depends on psvf_pkg for the request and register codes.
`timescale 1ns / 100ps

module psvf_synth_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam longint OUT_HI = (64'sd1 <<< (psvf_pkg::OUT_BITS - 1)) - 1;
    localparam longint OUT_LO = -(64'sd1 <<< (psvf_pkg::OUT_BITS - 1));

    // Note frequencies of the top octave, unsigned Q16.16
    localparam longint NOTE_HZ [12] = '{
        548668578, 581294109, 615859655, 652480576, 691279090, 732384684,
        775934544, 822074013, 870957077, 922746880, 977616265, 1035748353
    };

    // Voice state mirror
    logic [31:0]        phase_acc [psvf_pkg::VOICES];
    logic [23:0]        env_cnt   [psvf_pkg::VOICES];
    logic               active    [psvf_pkg::VOICES];
    logic [6:0]         note_num  [psvf_pkg::VOICES];
    logic [6:0]         note_vel  [psvf_pkg::VOICES];
    logic signed [31:0] lp_state  [psvf_pkg::VOICES];
    logic signed [31:0] bp_state  [psvf_pkg::VOICES];

    // Register mirror
    logic [31:0] amp_times_r, filt_times_r;
    logic [15:0] amp_sus_r, filt_sus_r, cutoff_r, reso_r;
    logic [8:0]  wave_r;

    logic [23:0] sample_q [$];

    assign o_pending = sample_q.size();

    function automatic longint clamp32(longint x);
        longint r;
        r = x;
        if (x > 64'sd2147483647) r = 64'sd2147483647;
        if (x < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic longint step_of(logic [6:0] note);
        longint oct, inc;
        oct = note / 12;
        inc = (NOTE_HZ[note % 12] << 16) / psvf_pkg::SAMPLE_RATE;
        if (oct > 10) oct = 10;
        return (inc >> (10 - oct)) & 64'hFFFFFFFF;
    endfunction

    function automatic longint env_of(longint e, logic [31:0] times, longint sus);
        longint att, dec, t, lvl;
        att = times[15:0];
        dec = times[31:16];
        if (e < att) return (e << 16) / att;
        t = e - att;
        if (dec == 0 || t >= dec) return sus;
        lvl = ((dec - t) << 16) / dec;
        return (lvl > sus) ? lvl : sus;
    endfunction

    function automatic longint scale127(longint p);
        if (p >= 0) return p / 127;
        return -((-p + 126) / 127);
    endfunction

    // Advance every voice by one sample and return the saturated mix
    function automatic logic [23:0] mix_tick();
        longint acc, damp, src, lvl, f, g, coef, lo, hi, s;
        logic [7:0]  duty;
        logic [31:0] thr;
        acc  = 0;
        damp = 65536 - longint'(reso_r);
        duty = wave_r[7:0];
        thr  = 32'h0 - {duty, 24'h0};
        for (int v = 0; v < psvf_pkg::VOICES; v++) begin
            src = 0;
            if (active[v]) begin
                phase_acc[v] = phase_acc[v] + 32'(step_of(note_num[v]));
                if (env_cnt[v] != psvf_pkg::ENV_MAX) env_cnt[v] = env_cnt[v] + 1;
                lvl = env_of(env_cnt[v], amp_times_r, amp_sus_r);
                if (wave_r[8]) begin
                    src = (duty != 0 && phase_acc[v] >= thr) ? lvl * 8 : -lvl * 8;
                end else begin
                    s   = longint'({32'h0, phase_acc[v]}) - (64'sd1 <<< 31);
                    src = (s * lvl) >>> 26;
                end
            end
            f    = env_of(env_cnt[v], filt_times_r, filt_sus_r);
            g    = (((f * f) >> 16) * f) >> 16;
            coef = ((g * cutoff_r) >> 16) & 64'hFFFFFFFF;
            lo   = clamp32(longint'(lp_state[v]) + ((coef * bp_state[v]) >>> 16));
            hi   = clamp32(src - lo - ((damp * bp_state[v]) >>> 16));
            bp_state[v] = 32'(clamp32(longint'(bp_state[v]) + ((coef * hi) >>> 16)));
            lp_state[v] = 32'(lo);
            acc += scale127(lo * note_vel[v]);
        end
        if (acc > OUT_HI) acc = OUT_HI;
        if (acc < OUT_LO) acc = OUT_LO;
        return acc[23:0];
    endfunction

    always @(posedge i_clk) begin
        logic [3:0] ch;
        logic [23:0] want;
        if (!i_rst_n) begin
            for (int v = 0; v < psvf_pkg::VOICES; v++) begin
                phase_acc[v] = '0;
                env_cnt[v]   = '0;
                active[v]    = 1'b0;
                note_num[v]  = '0;
                note_vel[v]  = '0;
                lp_state[v]  = '0;
                bp_state[v]  = '0;
            end
            amp_times_r  = 32'd268435456;
            amp_sus_r    = 16'd26214;
            filt_times_r = 32'd268435456;
            filt_sus_r   = 16'd26214;
            cutoff_r     = 16'd6554;
            reso_r       = 16'd19661;
            wave_r       = 9'd128;
            sample_q.delete();
            o_errors     = 0;
        end else begin
            // Update register mirror
            if (i_cfg_valid && i_cfg_ready) begin
                case (psvf_pkg::t_reg'(i_cfg_index))
                    psvf_pkg::REG_AMP_TIMES:    amp_times_r  = i_cfg_data;
                    psvf_pkg::REG_AMP_SUSTAIN:  amp_sus_r    = i_cfg_data[15:0];
                    psvf_pkg::REG_FILT_TIMES:   filt_times_r = i_cfg_data;
                    psvf_pkg::REG_FILT_SUSTAIN: filt_sus_r   = i_cfg_data[15:0];
                    psvf_pkg::REG_CUTOFF:       cutoff_r     = i_cfg_data[15:0];
                    psvf_pkg::REG_RESONANCE:    reso_r       = i_cfg_data[15:0];
                    psvf_pkg::REG_WAVEFORM:     wave_r       = i_cfg_data[8:0];
                    default: ;
                endcase
            end
            // Compare the oldest expected sample
            if (i_m_tvalid && i_m_tready) begin
                if (sample_q.size() == 0) begin
                    $display("%0t: unexpected sample, expected none actual %h",
                             $time, i_m_tdata);
                    o_errors++;
                end else begin
                    want = sample_q.pop_front();
                    if (want !== i_m_tdata) begin
                        $display("%0t: sample_out mismatch, expected %h actual %h",
                                 $time, want, i_m_tdata);
                        o_errors++;
                    end
                end
            end
            // Apply an accepted request
            if (i_s_tvalid && i_s_tready) begin
                ch = i_s_tdata[3:0];
                case (psvf_pkg::t_op'(i_s_tuser))
                    psvf_pkg::OP_TICK: sample_q.push_back(mix_tick());
                    psvf_pkg::OP_NOTE_ON: begin
                        note_num[ch] = i_s_tdata[10:4];
                        note_vel[ch] = i_s_tdata[17:11];
                        active[ch]   = 1'b1;
                        env_cnt[ch]  = '0;
                    end
                    psvf_pkg::OP_NOTE_OFF: active[ch] = 1'b0;
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/polyphonic_svf_synth_voice_engine_top_tb.sv
// Testbench top for the polyphonic SVF voice engine: clock, reset, stimulus and verdict.
// Depends on psvf_pkg, the engine top and psvf_synth_checker.
`timescale 1ns / 100ps

module polyphonic_svf_synth_voice_engine_top_tb;

    localparam longint CYCLE_LIMIT = 64'd16000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    int     err_count;
    int     samples_due;
    logic   hold_go = 1'b0;
    logic   hold_off = 1'b0;
    longint cycles = 0;

    polyphonic_svf_synth_voice_engine_top u_top (.*);

    psvf_synth_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_errors   (err_count),
        .o_pending  (samples_due)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Hold off the sample sink for a long stretch once
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (6000) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Sample sink with random stalls
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            stall = $urandom_range(0, 4);
            if (stall > 0 || hold_off) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // Offer one request; valid stays high for a back-to-back successor
    task automatic send_req(psvf_pkg::t_op op, logic [3:0] ch, logic [6:0] pitch,
                            logic [6:0] vel);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {6'b0, vel, pitch, ch};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic write_reg(psvf_pkg::t_reg idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Let the engine drain before touching registers or ending
    task automatic drain();
        i_s_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (samples_due != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic load_setting(logic [31:0] at, logic [15:0] asus, logic [31:0] ft,
                                logic [15:0] fsus, logic [15:0] cut, logic [15:0] res,
                                logic [8:0] wave);
        write_reg(psvf_pkg::REG_AMP_TIMES, at);
        write_reg(psvf_pkg::REG_AMP_SUSTAIN, {16'h0, asus});
        write_reg(psvf_pkg::REG_FILT_TIMES, ft);
        write_reg(psvf_pkg::REG_FILT_SUSTAIN, {16'h0, fsus});
        write_reg(psvf_pkg::REG_CUTOFF, {16'h0, cut});
        write_reg(psvf_pkg::REG_RESONANCE, {16'h0, res});
        write_reg(psvf_pkg::REG_WAVEFORM, {23'h0, wave});
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random requests, weighted toward notes and ticks
    task automatic random_reqs(int n);
        int            sel;
        psvf_pkg::t_op op;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 36) op = psvf_pkg::OP_TICK;
            else if (sel < 70) op = psvf_pkg::OP_NOTE_ON;
            else if (sel < 92) op = psvf_pkg::OP_NOTE_OFF;
            else op = psvf_pkg::OP_NONE;
            send_req(op, 4'($urandom), 7'($urandom), 7'($urandom));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults written back plus the spare index
        load_setting(32'd268435456, 16'd26214, 32'd268435456, 16'd26214,
                     16'd6554, 16'd19661, 9'd128);
        write_reg(psvf_pkg::REG_SPARE, 32'hFFFFFFFF);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);

        // Directed: field extremes, every op, zero velocity, retrigger, unused op
        send_req(psvf_pkg::OP_NOTE_ON, 4'd0, 7'd0, 7'd127);
        send_req(psvf_pkg::OP_NOTE_ON, 4'd15, 7'd127, 7'd1);
        send_req(psvf_pkg::OP_NOTE_ON, 4'd3, 7'd69, 7'd0);
        send_req(psvf_pkg::OP_TICK, 4'd15, 7'd127, 7'd127);
        send_req(psvf_pkg::OP_TICK, 4'd0, 7'd0, 7'd0);
        send_req(psvf_pkg::OP_NOTE_OFF, 4'd0, 7'd127, 7'd127);
        send_req(psvf_pkg::OP_TICK, 4'd0, 7'd0, 7'd0);
        send_req(psvf_pkg::OP_NONE, 4'd15, 7'd127, 7'd127);
        send_req(psvf_pkg::OP_TICK, 4'd0, 7'd0, 7'd0);
        send_req(psvf_pkg::OP_NOTE_ON, 4'd0, 7'd60, 7'd100);
        send_req(psvf_pkg::OP_NOTE_ON, 4'd7, 7'd119, 7'd64);
        send_req(psvf_pkg::OP_TICK, 4'd0, 7'd0, 7'd0);
        send_req(psvf_pkg::OP_TICK, 4'd0, 7'd0, 7'd0);
        send_req(psvf_pkg::OP_NOTE_OFF, 4'd15, 7'd0, 7'd0);
        send_req(psvf_pkg::OP_TICK, 4'd0, 7'd0, 7'd0);
        send_req(psvf_pkg::OP_TICK, 4'd0, 7'd0, 7'd0);
        random_reqs(440);
        drain();

        // Extremes: zero envelope times, full sustain, pulse with zero duty
        load_setting(32'h0, 16'hFFFF, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'h100);
        send_req(psvf_pkg::OP_NOTE_ON, 4'd5, 7'd127, 7'd127);
        send_req(psvf_pkg::OP_TICK, 4'd0, 7'd0, 7'd0);
        send_req(psvf_pkg::OP_TICK, 4'd0, 7'd0, 7'd0);
        random_reqs(440);
        drain();

        // Short envelopes, full duty pulse, no resonance; sink stalls long here
        load_setting({16'd20, 16'd5}, 16'h0, {16'd9, 16'd3}, 16'h4000,
                     16'h8000, 16'h0, 9'h1FF);
        hold_go <= 1'b1;
        random_reqs(440);
        drain();

        // Longest amplitude times, short random filter times, random levels and wave
        load_setting(32'hFFFFFFFF, 16'($urandom), {16'($urandom_range(0, 40)),
                     16'($urandom_range(0, 40))}, 16'($urandom), 16'($urandom),
                     16'($urandom), 9'($urandom));
        random_reqs(100);
        drain();

        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
